>>> rtl/div64_pkg.sv
package div64_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 64;
  localparam int unsigned FIELD_WIDTH    = 64;
  localparam int unsigned OP_WIDTH       = 2;

  typedef enum logic [OP_WIDTH-1:0] {
    OP_UQUOT = 2'd0,
    OP_UREM  = 2'd1,
    OP_SQUOT = 2'd2,
    OP_SREM  = 2'd3
  } op_t;

  // control handed from the sequencer to every cell
  typedef struct packed {
    logic load;
    logic step;
  } cell_ctl_t;

endpackage

>>> rtl/div64_cell.sv
// one bit slice of the partial remainder and quotient registers
module div64_cell (
  input  logic                  clk,
  input  div64_pkg::cell_ctl_t  ctl,
  input  logic                  load_rem,
  input  logic                  load_quo,
  input  logic                  rem_in,
  input  logic                  quo_in,
  input  logic                  diff,
  input  logic                  take,
  output logic                  rem_out,
  output logic                  quo_out
);

  logic rem_r, rem_nxt;
  logic quo_r, quo_nxt;

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    if (ctl.load) begin
      rem_nxt = load_rem;
      quo_nxt = load_quo;
    end else if (ctl.step) begin
      // shifted remainder bit, or the difference bit when subtracting
      rem_nxt = take ? diff : rem_in;
      quo_nxt = quo_in;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign rem_out = rem_r;
  assign quo_out = quo_r;

endmodule

>>> rtl/divider_64bit_signed_unsigned.sv
// channel | ports                                        | direction
// in      | in_valid in_ready in_operation in_dividend in_divisor | into block
// out     | out_valid out_ready out_result out_divide_by_zero     | out of block
//
// each word passes a load step with operand magnitude negation, then
// DATA_WIDTH shift-subtract steps through the row of bit cells (one quotient
// bit per step, the wide subtract sets the pace), then a sign fix-up step that
// writes the output register once that register is free.
// reset is synchronous active low and clears the sequencer and output valid.
// the next word is taken while a finished result still waits for out_ready;
// a stalled output only holds the row once the next division is done.
module divider_64bit_signed_unsigned #(
  parameter int unsigned DATA_WIDTH = div64_pkg::DATA_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [div64_pkg::OP_WIDTH-1:0]      in_operation,
  input  logic [div64_pkg::FIELD_WIDTH-1:0]   in_dividend,
  input  logic [div64_pkg::FIELD_WIDTH-1:0]   in_divisor,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [div64_pkg::FIELD_WIDTH-1:0]   out_result,
  output logic                                out_divide_by_zero
);

  localparam int unsigned CW = $clog2(DATA_WIDTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_FIX,
    ST_HOLD
  } state_t;

  state_t state_r;
  logic [CW-1:0] cnt_r;

  // per-word flags captured at load
  logic want_rem_r, neg_quo_r, neg_rem_r, dbz_r;
  logic [DATA_WIDTH-1:0] div_r;      // divisor magnitude
  logic [DATA_WIDTH-1:0] orig_n_r;   // dividend as given, for divide by zero

  logic [DATA_WIDTH-1:0] rem_q, quo_q;
  logic [DATA_WIDTH-1:0] rem_sh, quo_sh;
  logic [DATA_WIDTH-1:0] diff;
  logic [DATA_WIDTH:0]   sub_w;
  logic take;

  logic [DATA_WIDTH-1:0] n_in, d_in, mag_n, mag_d;
  logic is_signed, n_neg, d_neg;
  div64_pkg::cell_ctl_t ctl;

  logic out_valid_r;
  logic [div64_pkg::FIELD_WIDTH-1:0] out_result_r;
  logic out_dbz_r;

  assign n_in      = in_dividend[DATA_WIDTH-1:0];
  assign d_in      = in_divisor[DATA_WIDTH-1:0];
  assign is_signed = in_operation[1];
  assign n_neg     = is_signed & n_in[DATA_WIDTH-1];
  assign d_neg     = is_signed & d_in[DATA_WIDTH-1];
  assign mag_n     = n_neg ? (~n_in + 1'b1) : n_in;
  assign mag_d     = d_neg ? (~d_in + 1'b1) : d_in;

  assign in_ready = (state_r == ST_IDLE);
  assign ctl.load = in_valid & in_ready;
  assign ctl.step = (state_r == ST_STEP);

  // shift: remainder takes the top quotient bit, quotient shifts in the new bit
  assign rem_sh = {rem_q[DATA_WIDTH-2:0], quo_q[DATA_WIDTH-1]};
  assign sub_w  = {1'b0, rem_sh} - {1'b0, div_r};
  assign diff   = sub_w[DATA_WIDTH-1:0];
  assign take   = rem_q[DATA_WIDTH-1] | ~sub_w[DATA_WIDTH];
  assign quo_sh = {quo_q[DATA_WIDTH-2:0], take};

  // row of bit cells: dividend magnitude enters the quotient register, remainder starts at zero
  for (genvar g = 0; g < DATA_WIDTH; g++) begin : g_cell
    div64_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .load_rem (1'b0),
      .load_quo (mag_n[g]),
      .rem_in   (rem_sh[g]),
      .quo_in   (quo_sh[g]),
      .diff     (diff[g]),
      .take     (take),
      .rem_out  (rem_q[g]),
      .quo_out  (quo_q[g])
    );
  end

  logic [DATA_WIDTH-1:0] fix_val;
  always_comb begin
    if (dbz_r) begin
      fix_val = want_rem_r ? orig_n_r : '0;
    end else if (want_rem_r) begin
      fix_val = neg_rem_r ? (~rem_q + 1'b1) : rem_q;
    end else begin
      fix_val = neg_quo_r ? (~quo_q + 1'b1) : quo_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // the fix-up states drive out_valid_r themselves
      if (out_valid_r && out_ready && state_r != ST_FIX && state_r != ST_HOLD) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (ctl.load) begin
            state_r    <= ST_STEP;
            cnt_r      <= CW'(DATA_WIDTH);
            want_rem_r <= in_operation[0];
            neg_quo_r  <= n_neg ^ d_neg;
            neg_rem_r  <= n_neg;
            dbz_r      <= (d_in == '0);
            div_r      <= mag_d;
            orig_n_r   <= n_in;
          end
        end
        ST_STEP: begin
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == CW'(1)) begin
            state_r <= ST_FIX;
          end
        end
        ST_FIX, ST_HOLD: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_result_r <= div64_pkg::FIELD_WIDTH'(fix_val);
            out_dbz_r    <= dbz_r;
            state_r      <= ST_IDLE;
          end else begin
            state_r <= ST_HOLD;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result         = out_result_r;
  assign out_divide_by_zero = out_dbz_r;

  // the row shifts only while stepping
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STEP) |-> (cnt_r != '0)) else $error("step count ran out");
  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ready) else $error("ready while busy");
  a_fix_after_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIX) |-> $past(state_r == ST_STEP)) else $error("fix without steps");
  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HOLD) |-> out_valid_r) else $error("hold with empty output");

endmodule

>>> verif/div64_checker.sv
module div64_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [63:0] in_dividend,
  input  logic [63:0] in_divisor,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] out_result,
  input  logic        out_divide_by_zero,
  output int          fail_count,
  output int          pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [63:0] result;
    logic        dbz;
  } div_answer_t;

  div_answer_t answer_q[$];

  function automatic div_answer_t divide_word(div64_pkg::op_t op, logic [63:0] n,
                                              logic [63:0] d);
    div_answer_t a;
    logic        is_signed;
    logic        want_rem;
    logic        n_neg;
    logic        d_neg;
    logic [63:0] mag_n;
    logic [63:0] mag_d;
    logic [63:0] q;
    logic [63:0] r;
    is_signed = (op == div64_pkg::OP_SQUOT) || (op == div64_pkg::OP_SREM);
    want_rem  = (op == div64_pkg::OP_UREM) || (op == div64_pkg::OP_SREM);
    a.dbz = (d == 64'd0);
    if (a.dbz) begin
      a.result = want_rem ? n : 64'd0;
      return a;
    end
    n_neg = is_signed && n[63];
    d_neg = is_signed && d[63];
    mag_n = n_neg ? -n : n;
    mag_d = d_neg ? -d : d;
    q = mag_n / mag_d;
    r = mag_n % mag_d;
    if (want_rem) a.result = n_neg ? -r : r;
    else a.result = (n_neg != d_neg) ? -q : q;
    return a;
  endfunction

  initial begin
    fail_count = 0;
    pending_count = 0;
  end

  always @(posedge clk) begin
    div_answer_t exp_a;
    if (rst_n && in_valid && in_ready)
      answer_q.push_back(divide_word(div64_pkg::op_t'(in_operation), in_dividend, in_divisor));
    if (rst_n && out_valid && out_ready) begin
      if (answer_q.size() == 0) begin
        $error("result word with nothing expected: %h", out_result);
        fail_count++;
      end else begin
        exp_a = answer_q.pop_front();
        if (out_result !== exp_a.result) begin
          $error("result: expected %h actual %h", exp_a.result, out_result);
          fail_count++;
        end
        if (out_divide_by_zero !== exp_a.dbz) begin
          $error("divide_by_zero: expected %b actual %b", exp_a.dbz, out_divide_by_zero);
          fail_count++;
        end
      end
    end
    pending_count = answer_q.size();
  end
endmodule

>>> verif/divider_64bit_signed_unsigned_tb.sv
module divider_64bit_signed_unsigned_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] MOST_NEG = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MOST_POS = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_operation = div64_pkg::OP_UQUOT;
  logic [63:0] in_dividend = '0;
  logic [63:0] in_divisor = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_result;
  logic        out_divide_by_zero;
  int          fail_count;
  int          pending_count;

  // idle percentages per phase, one for the sender and one for the receiver
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  divider_64bit_signed_unsigned u_dut (.*);

  div64_checker u_checker (.*);

  // receiver: random stall, or long hold-off when pressure is on
  always @(posedge clk) begin
    if (hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // pick operands that hit small values, signs and extremes
  function automatic logic [63:0] pick_operand();
    case ($urandom_range(7))
      0: return {$urandom, $urandom};
      1: return 64'($urandom_range(15));
      2: return -64'($urandom_range(15));
      3: return MOST_NEG;
      4: return ALL_ONES;
      5: return {32'd0, $urandom};
      6: return {$urandom, $urandom} >> $urandom_range(63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // offer one word and hold it until accepted; valid drops only while idling
  task automatic send_word(div64_pkg::op_t op, logic [63:0] n, logic [63:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_dividend  <= n;
    in_divisor   <= d;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  task automatic send_random(int count);
    logic [63:0] d;
    repeat (count) begin
      d = pick_operand();
      if ($urandom_range(19) == 0) d = '0;
      send_word(div64_pkg::op_t'($urandom_range(3)), pick_operand(), d);
    end
  endtask

  initial begin
    div64_pkg::op_t op;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: every op on extremes, zero divisor, most negative over minus one
    for (int k = 0; k < 4; k++) begin
      op = div64_pkg::op_t'(k);
      send_word(op, MOST_NEG, ALL_ONES);
      send_word(op, 64'd12345, 64'd0);
      send_word(op, ALL_ONES, 64'd1);
      send_word(op, MOST_POS, MOST_NEG);
      send_word(op, -64'd7, 64'd2);
      send_word(op, 64'd7, -64'd2);
    end
    send_random(100);
    send_idle_pct = 80;
    send_random(60);
    send_idle_pct = 0;
    recv_stall_pct = 80;
    send_random(60);
    send_idle_pct = 7;
    recv_stall_pct = 7;
    send_random(100);
    // pressure: receiver holds off long enough for the input to back up
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      send_random(20);
    join
    send_random(60);
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (fail_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

>>> sim.f
rtl/div64_pkg.sv
rtl/div64_cell.sv
rtl/divider_64bit_signed_unsigned.sv
verif/div64_checker.sv
verif/divider_64bit_signed_unsigned_tb.sv
